/* sv/lpcp_pkg.sv */
// lidar point camera projection: shared constants and types
// depends on nothing
`timescale 1ns / 1ps
package lpcp_pkg;
   localparam int IMAGE_WIDTH = 1280;
   localparam int IMAGE_HEIGHT = 960;
   localparam int INDEX_BITS = 16;
   localparam int COL_W = 11;
   localparam int ROW_W = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic signed [33:0] BOX_HALF = 34'sd3276800;
   localparam logic signed [33:0] BOX_NEAR = 34'sd32768;
   // division: quotient bits produced (quotient |q| < 2^QB else out of image)
   localparam int QB = 14;
   localparam int DIVW = 84;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COS = 3'd0, REG_SIN = 3'd1, REG_R0LO = 3'd2, REG_R0HI = 3'd3,
      REG_R1LO = 3'd4, REG_R1HI = 3'd5, REG_R2LO = 3'd6, REG_R2HI = 3'd7
   } csr_index_type;
endpackage

/* sv/lidar_point_camera_projection_unit.sv */
// lidar point camera projection top level: rotate, box test, project, divide
// depends on lpcp_pkg
// pipeline depth: 6 + 2*QB (=34) register stages
// throughput: one request per cycle while the output is not stalled; the divider pipeline is bit-per-stage
// synchronous active-high reset sets the CSR registers to their defaults and clears all valid bits
// a stall freezes the whole pipeline; nothing is lost or repeated
`timescale 1ns / 1ps
module lidar_point_camera_projection_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [15:0] req_point_id,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [15:0] rsp_point_id_out,
   output logic [lpcp_pkg::COL_W-1:0] rsp_pixel_col,
   output logic [lpcp_pkg::ROW_W-1:0] rsp_pixel_row,
   output logic rsp_inside_box,
   output logic rsp_hit,
   input  logic csr_write,
   input  logic [lpcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lpcp_pkg::CSR_DATA_W-1:0] csr_data
);
   import lpcp_pkg::*;

   localparam int NS = 2 * QB;

   logic signed [17:0] cos_ff, sin_ff;
   logic [63:0] proj_ff [6];
   logic adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= 18'sd65536;
         sin_ff <= '0;
         for (int i = 0; i < 6; i++) proj_ff[i] <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_COS: cos_ff <= csr_data[17:0];
            REG_SIN: sin_ff <= csr_data[17:0];
            default: proj_ff[csr_index - 3'd2] <= csr_data;
         endcase
      end
   end

   function automatic logic signed [31:0] coef(input int r, input int k);
      logic [63:0] w;
      begin
         w = proj_ff[2*r + k/2];
         coef = (k % 2 == 1) ? w[63:32] : w[31:0];
      end
   endfunction

   // output holding register; pipeline advances when no result is held up
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // stage 1: rotation products
   logic v1_ff;
   logic [15:0] id1_ff;
   logic signed [31:0] z1_ff;
   logic signed [49:0] xc_ff, ys_ff, xs_ff, yc_ff;
   // stage 2: rotated point
   logic v2_ff;
   logic [15:0] id2_ff;
   logic signed [33:0] rx_ff, ry_ff, z2_ff;
   // stage 3: box test and projection products
   logic v3_ff, in3_ff;
   logic [15:0] id3_ff;
   logic signed [65:0] pm_ff [3][3];
   logic signed [31:0] t3_ff [3];
   // stage 4: u v w
   logic v4_ff, in4_ff;
   logic [15:0] id4_ff;
   logic signed [67:0] u_ff, vv_ff, w_ff;
   // stage 5: signed to magnitude numerators
   logic v5_ff, in5_ff, wpos5_ff, nu5_ff, nv5_ff;
   logic [15:0] id5_ff;
   logic [DIVW-1:0] nu_ff, nvm_ff, d5_ff;

   logic signed [67:0] u_in, v_in, w_in;
   logic signed [69:0] nus, nvs;

   always_comb begin
      u_in = 68'(pm_ff[0][0]) + 68'(pm_ff[0][1]) + 68'(pm_ff[0][2])
           + 68'(signed'({t3_ff[0], 16'd0}));
      v_in = 68'(pm_ff[1][0]) + 68'(pm_ff[1][1]) + 68'(pm_ff[1][2])
           + 68'(signed'({t3_ff[1], 16'd0}));
      w_in = 68'(pm_ff[2][0]) + 68'(pm_ff[2][1]) + 68'(pm_ff[2][2])
           + 68'(signed'({t3_ff[2], 16'd0}));
      nus = 70'(u_ff) * 70'sd2 + 70'(w_ff);
      nvs = 70'(vv_ff) * 70'sd2 + 70'(w_ff);
   end

   logic signed [33:0] rx_in, ry_in;
   always_comb begin
      rx_in = 34'((51'(xc_ff) - 51'(ys_ff)) >>> 16);
      ry_in = 34'((51'(xs_ff) + 51'(yc_ff)) >>> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid; v2_ff <= v1_ff; v3_ff <= v2_ff;
         v4_ff <= v3_ff; v5_ff <= v4_ff;
      end
      if (adv) begin
         id1_ff <= req_point_id;
         z1_ff <= req_pos_z;
         xc_ff <= req_pos_x * cos_ff;
         ys_ff <= req_pos_y * sin_ff;
         xs_ff <= req_pos_x * sin_ff;
         yc_ff <= req_pos_y * cos_ff;

         id2_ff <= id1_ff;
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         z2_ff <= 34'(z1_ff);

         id3_ff <= id2_ff;
         in3_ff <= ry_ff >= -BOX_HALF && ry_ff <= BOX_HALF &&
                   z2_ff >= -BOX_HALF && z2_ff <= BOX_HALF &&
                   rx_ff >= BOX_NEAR && rx_ff <= BOX_HALF;
         for (int r = 0; r < 3; r++) begin
            pm_ff[r][0] <= coef(r, 0) * rx_ff;
            pm_ff[r][1] <= coef(r, 1) * ry_ff;
            pm_ff[r][2] <= coef(r, 2) * z2_ff;
            t3_ff[r] <= coef(r, 3);
         end

         id4_ff <= id3_ff;
         in4_ff <= in3_ff;
         u_ff <= u_in;
         vv_ff <= v_in;
         w_ff <= w_in;

         id5_ff <= id4_ff;
         in5_ff <= in4_ff;
         wpos5_ff <= w_ff > 68'sd0;
         nu5_ff <= nus < 0;
         nv5_ff <= nvs < 0;
         nu_ff <= DIVW'(nus < 0 ? -nus : nus);
         nvm_ff <= DIVW'(nvs < 0 ? -nvs : nvs);
         d5_ff <= DIVW'(70'(w_ff) * 70'sd2);
      end
   end

   // restoring divider, one quotient bit per stage; remainder shown as
   // upper quotient overflow flag plus running remainder
   logic dv_ff [NS+1];
   logic [15:0] did_ff [NS+1];
   logic din_ff [NS+1], dok_ff [NS+1], dnu_ff [NS+1], dnv_ff [NS+1];
   logic [DIVW-1:0] dd_ff [NS+1], ru_ff [NS+1], rv_ff [NS+1];
   logic [QB-1:0] qu_ff [NS+1], qv_ff [NS+1];

   always_comb begin
      dv_ff[0] = v5_ff; did_ff[0] = id5_ff; din_ff[0] = in5_ff;
      dok_ff[0] = in5_ff && wpos5_ff; dnu_ff[0] = nu5_ff; dnv_ff[0] = nv5_ff;
      dd_ff[0] = d5_ff; ru_ff[0] = nu_ff; rv_ff[0] = nvm_ff;
      qu_ff[0] = '0; qv_ff[0] = '0;
   end

   for (genvar g = 0; g < NS; g++) begin : g_div
      localparam int B = QB - 1 - g / 2;
      logic [DIVW-1:0] ru_in, rv_in;
      logic [QB-1:0] qu_in, qv_in;
      logic ok_in;
      always_comb begin
         ru_in = ru_ff[g]; rv_in = rv_ff[g];
         qu_in = qu_ff[g]; qv_in = qv_ff[g]; ok_in = dok_ff[g];
         if (g % 2 == 0) begin
            // overflow check on first stage, then subtract
            if (g == 0) begin
               if ((ru_ff[g] >> QB) >= dd_ff[g] && !dnu_ff[g]) ok_in = 1'b0;
               if ((rv_ff[g] >> QB) >= dd_ff[g] && !dnv_ff[g]) ok_in = 1'b0;
            end
            if ((ru_ff[g] >> B) >= dd_ff[g]) begin
               ru_in = ru_ff[g] - (dd_ff[g] << B);
               qu_in[B] = 1'b1;
            end
         end else begin
            if ((rv_ff[g] >> B) >= dd_ff[g]) begin
               rv_in = rv_ff[g] - (dd_ff[g] << B);
               qv_in[B] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv_ff[g+1] <= 1'b0;
         else if (adv) dv_ff[g+1] <= dv_ff[g];
         if (adv) begin
            did_ff[g+1] <= did_ff[g]; din_ff[g+1] <= din_ff[g];
            dok_ff[g+1] <= ok_in; dnu_ff[g+1] <= dnu_ff[g]; dnv_ff[g+1] <= dnv_ff[g];
            dd_ff[g+1] <= dd_ff[g]; ru_ff[g+1] <= ru_in; rv_ff[g+1] <= rv_in;
            qu_ff[g+1] <= qu_in; qv_ff[g+1] <= qv_in;
         end
      end
   end

   // final check: negative numerator with nonzero quotient is off image;
   // truncation toward zero of a small negative gives 0
   logic hit_in;
   always_comb begin
      hit_in = dok_ff[NS]
         && !(dnu_ff[NS] && qu_ff[NS] != '0) && !(dnv_ff[NS] && qv_ff[NS] != '0)
         && 32'(qu_ff[NS]) < 32'(IMAGE_WIDTH) && 32'(qv_ff[NS]) < 32'(IMAGE_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= dv_ff[NS];
      if (adv) begin
         rsp_point_id_out <= did_ff[NS] & 16'((32'd1 << INDEX_BITS) - 1);
         rsp_inside_box <= din_ff[NS];
         rsp_hit <= hit_in;
         rsp_pixel_col <= hit_in ? COL_W'(qu_ff[NS]) : '0;
         rsp_pixel_row <= hit_in ? ROW_W'(qv_ff[NS]) : '0;
      end
   end
endmodule
